// ===== rtl/msa_pkg.sv =====
// Shared widths, status codes and controller/datapath interface types for the sample averager.
`timescale 1ns / 1ps

package msa_pkg;

   // Number of scanned channels (1 to 16)
   localparam int CHANNELS = 8;

   localparam int SAMPLE_W = 12;
   localparam int CHSEL_W  = 4;
   localparam int SUM_W    = 44;
   localparam int COUNT_W  = 32;
   localparam int STATUS_W = 2;

   // Index width into the per-channel arrays
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   // Divider step counter width; one quotient bit per divider step
   localparam int STEP_W = $clog2(SAMPLE_W);

   // Request command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

   // Commands from controller to datapath
   typedef struct packed {
      logic acc_en;      // add the incoming sample to the scan channel
      logic capture_en;  // latch the channel of a read transaction
      logic load_en;     // fetch and clear the channel, prime the divider
      logic div_en;      // one restoring division step
      logic out_load;    // move the result into the response register
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic bad_ch;
      logic empty;
   } dp_stat_type;

endpackage

// ===== rtl/msa_dpath.sv =====
// Datapath: per-channel sums and counts, scan position, serial divider and response register.
`timescale 1ns / 1ps

module msa_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  msa_pkg::dp_cmd_type            cmd,
   output msa_pkg::dp_stat_type           stat,
   input  logic [msa_pkg::SAMPLE_W-1:0]   req_sample_value,
   input  logic [msa_pkg::CHSEL_W-1:0]    req_read_channel,
   output logic [msa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [msa_pkg::SAMPLE_W-1:0]   rsp_average
);
   import msa_pkg::*;

   logic [SUM_W-1:0]    sum_ff   [CHANNELS];
   logic [COUNT_W-1:0]  count_ff [CHANNELS];
   logic [CH_W-1:0]     pos_ff, pos_in;
   logic [CHSEL_W-1:0]  rch_ff;

   logic [SUM_W-1:0]    rem_ff, dsor_ff;
   logic [SAMPLE_W-1:0] quo_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SAMPLE_W-1:0] rsp_average_ff;

   logic [CH_W-1:0]     rd_idx;
   logic [SUM_W-1:0]    rd_sum;
   logic [COUNT_W-1:0]  rd_count;
   logic                bad, empty, cnt_full, fits;

   // Single read port: scan position for samples, latched channel for reads
   assign rd_idx   = cmd.acc_en ? pos_ff : rch_ff[CH_W-1:0];
   assign rd_sum   = sum_ff[rd_idx];
   assign rd_count = count_ff[rd_idx];

   assign bad      = {1'b0, rch_ff} >= (CHSEL_W+1)'(CHANNELS);
   assign empty    = (rd_count == '0);
   assign cnt_full = &rd_count;
   assign fits     = (rem_ff >= dsor_ff);

   assign stat.bad_ch = bad;
   assign stat.empty  = empty;

   // Scan position wraps after the last channel
   always_comb begin
      if (pos_ff == CH_W'(CHANNELS - 1)) begin
         pos_in = '0;
      end else begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (cmd.acc_en) begin
         pos_ff <= pos_in;
      end
   end

   // Per-channel accumulators; a saturated count drops the sample
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i]   <= '0;
            count_ff[i] <= '0;
         end
      end else if (cmd.acc_en) begin
         if (!cnt_full) begin
            sum_ff[rd_idx]   <= rd_sum + SUM_W'(req_sample_value);
            count_ff[rd_idx] <= rd_count + 1'b1;
         end
      end else if (cmd.load_en && !bad) begin
         sum_ff[rd_idx]   <= '0;
         count_ff[rd_idx] <= '0;
      end
   end

   // Read transaction channel
   always_ff @(posedge clock) begin
      if (cmd.capture_en) begin
         rch_ff <= req_read_channel;
      end
   end

   // Restoring divider: the mean is below 4096, so only SAMPLE_W quotient bits are formed
   always_ff @(posedge clock) begin
      if (cmd.load_en) begin
         rem_ff  <= rd_sum;
         dsor_ff <= SUM_W'({rd_count, {(SAMPLE_W-1){1'b0}}});
         quo_ff  <= '0;
         if (bad) begin
            status_ff <= STATUS_BAD;
         end else if (empty) begin
            status_ff <= STATUS_EMPTY;
         end else begin
            status_ff <= STATUS_OK;
         end
      end else if (cmd.div_en) begin
         if (fits) begin
            rem_ff <= rem_ff - dsor_ff;
         end
         quo_ff  <= {quo_ff[SAMPLE_W-2:0], fits};
         dsor_ff <= dsor_ff >> 1;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff  <= status_ff;
         rsp_average_ff <= (status_ff == STATUS_OK) ? quo_ff : '0;
      end
   end

   assign rsp_status  = rsp_status_ff;
   assign rsp_average = rsp_average_ff;

endmodule

// ===== rtl/msa_ctrl.sv =====
// Controller: request handshake, read sequencing, divider step count and response valid.
`timescale 1ns / 1ps

module msa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_cmd,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output msa_pkg::dp_cmd_type   cmd,
   input  msa_pkg::dp_stat_type  stat
);
   import msa_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOAD   = 4'b0010,
      ST_DIV    = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              idle, accept, out_free;

   assign idle      = (state_ff == ST_IDLE);
   assign req_stall = !idle;
   assign accept    = req_valid && idle;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_READ) begin
                  cmd.capture_en = 1'b1;
                  state_in       = ST_LOAD;
               end else begin
                  cmd.acc_en = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            cmd.load_en = 1'b1;
            step_in     = '0;
            if (stat.bad_ch || stat.empty) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_en = 1'b1;
            step_in    = step_ff + 1'b1;
            if (step_ff == STEP_W'(SAMPLE_W - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid holds until taken
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/multichannel_sample_averager.sv =====
// A sample transaction is absorbed in its accept cycle; the next may follow at once.
// A read transaction latches its channel at accept, then runs load, 12 restoring divider
// steps and output load; an empty or bad channel skips the divider steps.
// One sample per cycle outside reads; reads are bounded by the one-bit-per-cycle divider.
// Synchronous active-high reset clears all sums, counts, the scan position and rsp_valid.
`timescale 1ns / 1ps

module multichannel_sample_averager (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [msa_pkg::SAMPLE_W-1:0]  req_sample_value,
   input  logic [msa_pkg::CHSEL_W-1:0]   req_read_channel,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [msa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [msa_pkg::SAMPLE_W-1:0]  rsp_average
);
   import msa_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   msa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (dp_cmd),
      .stat      (dp_stat)
   );

   msa_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .stat             (dp_stat),
      .req_sample_value (req_sample_value),
      .req_read_channel (req_read_channel),
      .rsp_status       (rsp_status),
      .rsp_average      (rsp_average)
   );

   // A response never reports a status code outside the defined set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_EMPTY ||
                     rsp_status == STATUS_BAD))
      else $error("undefined response status");

   // Non-ok responses carry a zero average
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_average == '0))
      else $error("nonzero average on error status");

   // A new response only appears at the end of a read sequence
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a read in progress");

   // At most one of accumulate, load, divide and output load is commanded at a time
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({dp_cmd.acc_en, dp_cmd.load_en, dp_cmd.div_en, dp_cmd.out_load}))
      else $error("conflicting datapath commands");

endmodule

// ===== tb/msa_checker.sv =====
// Channel monitor for the sample averager: predicts each read response and compares it.
`timescale 1ns / 1ps

module msa_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [msa_pkg::SAMPLE_W-1:0]  req_sample_value,
   input  logic [msa_pkg::CHSEL_W-1:0]   req_read_channel,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [msa_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [msa_pkg::SAMPLE_W-1:0]  rsp_average,
   output int                            mismatch_count,
   output int                            pending_reads
);
   import msa_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SAMPLE_W-1:0] average;
   } read_result_type;

   // Shadow copy of the per-channel accumulators and the scan pointer
   logic [SUM_W-1:0]   sum_model   [CHANNELS];
   logic [COUNT_W-1:0] count_model [CHANNELS];
   logic [CH_W-1:0]    scan_pos;
   read_result_type    expected_averages[$];
   int                 errors;

   // Add one scan sample to the channel under the scan pointer; a full count drops it
   task automatic absorb_sample(input logic [SAMPLE_W-1:0] value);
      if (count_model[scan_pos] != '1) begin
         sum_model[scan_pos]   = sum_model[scan_pos] + value;
         count_model[scan_pos] = count_model[scan_pos] + 1'b1;
      end
      scan_pos = (int'(scan_pos) + 1 >= CHANNELS) ? '0 : CH_W'(int'(scan_pos) + 1);
   endtask

   // Truncated mean of one channel, which is then cleared; bad channels touch nothing
   task automatic predict_average(input logic [CHSEL_W-1:0] ch, output read_result_type res);
      logic [SUM_W-1:0] quotient;
      logic [CH_W-1:0]  idx;
      idx         = ch[CH_W-1:0];
      res.average = '0;
      if (ch >= CHANNELS) begin
         res.status = STATUS_BAD;
      end else if (count_model[idx] == '0) begin
         res.status     = STATUS_EMPTY;
         sum_model[idx] = '0;
      end else begin
         quotient         = sum_model[idx] / count_model[idx];
         res.status       = STATUS_OK;
         res.average      = quotient[SAMPLE_W-1:0];
         sum_model[idx]   = '0;
         count_model[idx] = '0;
      end
   endtask

   task automatic note_mismatch(input string msg);
      errors++;
      if (errors <= 10)
         $display("%0t ns: %s", $realtime, msg);
   endtask

   // Track both channels on every edge
   always @(posedge clock) begin
      read_result_type want;
      read_result_type got;
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            sum_model[i]   = '0;
            count_model[i] = '0;
         end
         scan_pos = '0;
         expected_averages.delete();
         errors = 0;
      end else begin
         // Request transaction: samples update the shadow, reads queue a prediction
         if (req_valid && !req_stall) begin
            if (req_cmd == CMD_SAMPLE) begin
               absorb_sample(req_sample_value);
            end else begin
               predict_average(req_read_channel, want);
               expected_averages.push_back(want);
            end
         end
         // Response transaction: compare against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got.status  = rsp_status;
            got.average = rsp_average;
            if (expected_averages.size() == 0) begin
               note_mismatch($sformatf("unexpected response: status %0d average %0d",
                                       got.status, got.average));
            end else begin
               want = expected_averages.pop_front();
               if (got.status != want.status)
                  note_mismatch($sformatf("status: expected %0d, got %0d",
                                          want.status, got.status));
               if (got.average != want.average)
                  note_mismatch($sformatf("average: expected %0d, got %0d",
                                          want.average, got.average));
            end
         end
      end
      mismatch_count <= errors;
      pending_reads  <= expected_averages.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the sample averager: stimulus, response back-pressure and verdict.
`timescale 1ns / 1ps

module tb_top;
   import msa_pkg::*;

   localparam int ITEM_TARGET  = 700;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 20;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic                req_cmd          = CMD_SAMPLE;
   logic [SAMPLE_W-1:0] req_sample_value = '0;
   logic [CHSEL_W-1:0]  req_read_channel = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SAMPLE_W-1:0] rsp_average;

   int mismatch_count;
   int pending_reads;
   int items_sent  = 0;
   int idle_cycles = 0;
   int stall_run   = 0;
   bit steady      = 1'b0;

   always #2 clock = ~clock;

   multichannel_sample_averager u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_sample_value (req_sample_value),
      .req_read_channel (req_read_channel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_average      (rsp_average)
   );

   msa_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_sample_value (req_sample_value),
      .req_read_channel (req_read_channel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_average      (rsp_average),
      .mismatch_count   (mismatch_count),
      .pending_reads    (pending_reads)
   );

   // Sender idle time: mostly none or short, now and then long
   function automatic int next_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Converter values weighted toward both ends of the range
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return SAMPLE_W'($urandom_range(0, 4095));
   endfunction

   // Mostly valid channels, some out of range
   function automatic logic [CHSEL_W-1:0] pick_channel();
      if ($urandom_range(0, 6) == 0)
         return CHSEL_W'($urandom_range(CHANNELS, 15));
      return CHSEL_W'($urandom_range(0, CHANNELS - 1));
   endfunction

   // Present one transaction and hold it until accepted, then idle if chosen
   task automatic send_txn(input logic cmd, input logic [SAMPLE_W-1:0] value,
                           input logic [CHSEL_W-1:0] ch);
      int gap;
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_sample_value <= value;
      req_read_channel <= ch;
      do @(posedge clock); while (req_stall);
      items_sent++;
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Unused payload fields carry random junk
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      send_txn(CMD_SAMPLE, value, CHSEL_W'($urandom_range(0, 15)));
   endtask

   task automatic send_read(input logic [CHSEL_W-1:0] ch);
      send_txn(CMD_READ, SAMPLE_W'($urandom_range(0, 4095)), ch);
   endtask

   // Response back-pressure: free stretches, short stalls, occasional long stalls
   always @(posedge clock) begin
      int pick;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            rsp_stall <= 1'b0;
            stall_run <= $urandom_range(0, 30);
         end else if (pick < 93) begin
            rsp_stall <= 1'b1;
            stall_run <= $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_run <= $urandom_range(10, 60);
         end
      end
   end

   // Watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus and verdict
   initial begin
      int burst;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reads before any sample: empty channel, out-of-range at both ends
      send_read('0);
      send_read(CHSEL_W'(CHANNELS));
      send_read('1);
      // A full-scale then a zero sample on every channel
      repeat (CHANNELS) send_sample('1);
      repeat (CHANNELS) send_sample('0);
      send_read('0);
      send_read(CHSEL_W'(CHANNELS - 1));
      // Channel just cleared reads empty
      send_read('0);
      // Single full-scale sample gives the maximum mean
      send_sample('1);
      send_read('0);
      send_read(CHSEL_W'(CHANNELS > 1 ? 1 : 0));

      // Random scan bursts followed by a few reads
      while (items_sent < ITEM_TARGET) begin
         steady = ($urandom_range(0, 4) == 0);
         burst  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 24);
         repeat (burst) send_sample(pick_sample());
         repeat ($urandom_range(1, 3)) send_read(pick_channel());
      end
      steady    = 1'b0;
      req_valid <= 1'b0;

      // Drain outstanding reads, then give the block time for strays
      do @(posedge clock); while (pending_reads != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0 && pending_reads == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
